// File: sv/sat_pkg.sv
package sat_pkg;

	localparam int FUNC_W    = 1;
	localparam int ELEM_W    = 16;
	localparam int COORD_W   = 8;
	localparam int RUN_W     = 23;
	localparam int SUM_W     = 30;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_RECT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD_WR,
		ST_QRY_B,
		ST_QRY_C
	} sat_state_t;

endpackage

// File: sv/summed_area_table_query.sv
// channel   direction  handshake                  payload
// config    in         cfg_we                     cfg_index, cfg_data
// item      in         item_valid / item_stall    func, element_value, corners
// result    out        result_valid / result_stall rect_sum, status
//
// A load reads the entry above, then writes the new entry.
// A query reads two entries in ST_IDLE and two in ST_QRY_B on the two table read ports.
// One item is in flight at a time; the result register lets the next item in.
// A stalled result holds a query in its last cycle until the register frees.
// Reset clears control state only; table entries are undefined until loaded.
module summed_area_table_query #(
	parameter int MAX_DIM = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [sat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [sat_pkg::CFG_W-1:0]     cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic        [sat_pkg::FUNC_W-1:0]    func,
	input  logic signed [sat_pkg::ELEM_W-1:0]    element_value,
	input  logic        [sat_pkg::COORD_W-1:0]   top_row,
	input  logic        [sat_pkg::COORD_W-1:0]   left_col,
	input  logic        [sat_pkg::COORD_W-1:0]   bottom_row,
	input  logic        [sat_pkg::COORD_W-1:0]   right_col,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [sat_pkg::SUM_W-1:0]     rect_sum,
	output logic        [sat_pkg::STAT_W-1:0]    status
);

	import sat_pkg::*;

	localparam int RW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v);
		if (v == '0) begin
			return COORD_W'(1);
		end
		if (32'(v) > MAX_DIM) begin
			return COORD_W'(MAX_DIM);
		end
		return v;
	endfunction

	function automatic logic [RW-1:0] to_idx(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] m;
		m = v - COORD_W'(1);
		return RW'(m);
	endfunction

	function automatic logic [AW-1:0] mk_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
		return AW'(AW'(r) * AW'(MAX_DIM)) + AW'(c);
	endfunction

	sat_state_t state_q, state_d;

	logic [COORD_W-1:0] row_count_q, column_count_q;
	logic [COORD_W-1:0] rows_eff, cols_eff;
	logic [COORD_W-1:0] load_row_q, load_col_q;
	logic [RUN_W-1:0]   run_q;
	logic               load_done_q;

	logic               item_take, is_load;
	logic [COORD_W-1:0] cur_row, cur_col;
	logic [RUN_W-1:0]   run_base, run_new;
	logic [AW-1:0]      above_addr, cur_addr;
	logic [COORD_W-1:0] top_m1, left_m1;
	logic [AW-1:0]      addr_br, addr_tr, addr_bl, addr_tl;
	logic               q_bad;
	logic [STAT_W-1:0]  q_status;

	logic [AW-1:0]      wr_addr_s1;
	logic [RUN_W-1:0]   run_s1;
	logic               above_zero_s1;
	logic [AW-1:0]      addr_c_s1, addr_d_s1;
	logic               zero_b_s1, zero_c_s1, zero_d_s1;
	logic [STAT_W-1:0]  status_s1;
	logic [SUM_W-1:0]   part_s2;

	logic               rd_en_a, rd_en_b, mem_we, out_load;
	logic [AW-1:0]      rd_addr_a, rd_addr_b;
	logic [SUM_W-1:0]   rd_data_a, rd_data_b, wr_data, final_sum;

	logic               result_valid_q;
	logic [SUM_W-1:0]   rect_sum_q;
	logic [STAT_W-1:0]  status_q;

	assign rows_eff  = clamp_dim(row_count_q);
	assign cols_eff  = clamp_dim(column_count_q);
	assign item_take = item_valid && !item_stall;
	assign is_load   = (func == FUNC_LOAD);

	// start a new matrix after a complete load
	assign cur_row    = load_done_q ? COORD_W'(1) : load_row_q;
	assign cur_col    = load_done_q ? COORD_W'(1) : load_col_q;
	assign run_base   = load_done_q ? '0 : run_q;
	assign run_new    = run_base
		+ {{(RUN_W-ELEM_W){element_value[ELEM_W-1]}}, element_value};
	assign cur_addr   = mk_addr(to_idx(cur_row), to_idx(cur_col));
	assign above_addr = mk_addr(to_idx(cur_row - COORD_W'(1)), to_idx(cur_col));

	assign top_m1  = top_row - COORD_W'(1);
	assign left_m1 = left_col - COORD_W'(1);
	assign addr_br = mk_addr(to_idx(bottom_row), to_idx(right_col));
	assign addr_tr = mk_addr(to_idx(top_m1), to_idx(right_col));
	assign addr_bl = mk_addr(to_idx(bottom_row), to_idx(left_m1));
	assign addr_tl = mk_addr(to_idx(top_m1), to_idx(left_m1));

	assign q_bad = (top_row == '0) || (left_col == '0) || (bottom_row > rows_eff)
		|| (right_col > cols_eff) || (top_row > bottom_row) || (left_col > right_col);

	always_comb begin
		if (!load_done_q) begin
			q_status = STAT_INCOMPLETE;
		end else if (q_bad) begin
			q_status = STAT_BAD_RECT;
		end else begin
			q_status = STAT_OK;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		rd_en_a    = 1'b0;
		rd_en_b    = 1'b0;
		mem_we     = 1'b0;
		out_load   = 1'b0;
		rd_addr_a  = addr_c_s1;
		rd_addr_b  = addr_d_s1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				rd_addr_a  = is_load ? above_addr : addr_br;
				rd_addr_b  = addr_tr;
				if (item_valid) begin
					rd_en_a = 1'b1;
					rd_en_b = !is_load;
					state_d = is_load ? ST_LOAD_WR : ST_QRY_B;
				end
			end
			ST_LOAD_WR: begin
				mem_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_QRY_B: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				state_d = ST_QRY_C;
			end
			ST_QRY_C: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= COORD_W'(1);
			column_count_q <= COORD_W'(1);
			load_row_q     <= COORD_W'(1);
			load_col_q     <= COORD_W'(1);
			run_q          <= '0;
			load_done_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: begin
				end
			endcase
			load_row_q  <= COORD_W'(1);
			load_col_q  <= COORD_W'(1);
			run_q       <= '0;
			load_done_q <= 1'b0;
		end else if (item_take && is_load) begin
			load_done_q <= 1'b0;
			if (cur_col >= cols_eff) begin
				load_col_q <= COORD_W'(1);
				run_q      <= '0;
				if (cur_row >= rows_eff) begin
					load_row_q  <= COORD_W'(1);
					load_done_q <= 1'b1;
				end else begin
					load_row_q <= cur_row + COORD_W'(1);
				end
			end else begin
				load_row_q <= cur_row;
				load_col_q <= cur_col + COORD_W'(1);
				run_q      <= run_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			wr_addr_s1    <= cur_addr;
			run_s1        <= run_new;
			above_zero_s1 <= (cur_row == COORD_W'(1));
			addr_c_s1     <= addr_bl;
			addr_d_s1     <= addr_tl;
			zero_b_s1     <= (top_row == COORD_W'(1));
			zero_c_s1     <= (left_col == COORD_W'(1));
			zero_d_s1     <= (top_row == COORD_W'(1)) || (left_col == COORD_W'(1));
			status_s1     <= q_status;
		end
		if (state_q == ST_QRY_B) begin
			part_s2 <= rd_data_a - (zero_b_s1 ? '0 : rd_data_b);
		end
	end

	assign wr_data = {{(SUM_W-RUN_W){run_s1[RUN_W-1]}}, run_s1}
		+ (above_zero_s1 ? '0 : rd_data_a);
	assign final_sum = part_s2 - (zero_c_s1 ? '0 : rd_data_a)
		+ (zero_d_s1 ? '0 : rd_data_b);

	sat_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (SUM_W)
	) u_ram (
		.clk      (clk),
		.we       (mem_we),
		.wr_addr  (wr_addr_s1),
		.wr_data  (wr_data),
		.rd_en_a  (rd_en_a),
		.rd_addr_a(rd_addr_a),
		.rd_data_a(rd_data_a),
		.rd_en_b  (rd_en_b),
		.rd_addr_b(rd_addr_b),
		.rd_data_b(rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// zero the sum on any error status
	always_ff @(posedge clk) begin
		if (out_load) begin
			rect_sum_q <= (status_s1 == STAT_OK) ? final_sum : '0;
			status_q   <= status_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign rect_sum     = rect_sum_q;
	assign status       = status_q;

endmodule

// File: sv/sat_ram.sv
module sat_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int DW    = 30
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en_a,
	input  logic [AW-1:0] rd_addr_a,
	output logic [DW-1:0] rd_data_a,
	input  logic          rd_en_b,
	input  logic [AW-1:0] rd_addr_b,
	output logic [DW-1:0] rd_data_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_a) begin
			rd_data_a <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: sv/sat_check.sv
module sat_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic        [sat_pkg::FUNC_W-1:0] func,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic signed [sat_pkg::SUM_W-1:0]  rect_sum,
	input logic        [sat_pkg::STAT_W-1:0] status
);

	import sat_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(rect_sum) && $stable(status))
		else $error("stalled result beat changed");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != STAT_OK) |-> rect_sum == '0)
		else $error("error result with nonzero sum");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken on consecutive cycles");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall && (func == FUNC_QUERY), 3))
		else $error("result beat without a query three cycles earlier");

endmodule

bind summed_area_table_query sat_check u_sat_check (.*);
